@@ rtl/core/dtoi_pkg.sv @@
// dtoi_pkg: token codes, token and queue status types for the decimal text parser
// shared by the front classifier, the token queue and the back parser
// no dependencies
package dtoi_pkg;

    // character classes produced by the front end
    localparam int TOK_KIND_W = 3;
    localparam logic [TOK_KIND_W-1:0] TK_DIGIT = 3'd0;
    localparam logic [TOK_KIND_W-1:0] TK_SPACE = 3'd1;
    localparam logic [TOK_KIND_W-1:0] TK_PLUS  = 3'd2;
    localparam logic [TOK_KIND_W-1:0] TK_MINUS = 3'd3;
    localparam logic [TOK_KIND_W-1:0] TK_END   = 3'd4;
    localparam logic [TOK_KIND_W-1:0] TK_OTHER = 3'd5;

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int OUT_W   = 32;

    // queue depth must be a power of two so the pointers wrap by themselves
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [TOK_KIND_W-1:0] kind;
        logic [DIGIT_W-1:0]    digit;
    } t_tok;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/core/decimal_text_to_int32.sv @@
// decimal_text_to_int32: top level of the decimal text to signed integer parser
// depends on dtoi_pkg, dtoi_front, dtoi_queue and dtoi_back
//
// One character enters per item on the slave stream; a zero character ends the
// string and yields one result item on the master stream: tuser carries the
// success flag, tdata the signed value (zero on failure). Accepted form is
// optional leading whitespace, an optional sign and one or more digits with
// nothing after them; an empty string gives success with 0. The block takes one
// character every cycle while the queue has room: the classifier feeds a two-entry
// token queue and the parser retires one token per cycle with a shift-and-add
// accumulate unless a terminator waits on a held result; a held result stalls only
// the parser, and a terminator passes the token queue, then the result register.
module decimal_text_to_int32 #(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] parsed_value
    output logic [0:0]  m_axis_tuser    // [0] parse_ok
);
    import dtoi_pkg::*;

    t_tok    w_front_tok, w_q_tok;
    t_q_stat w_q_stat;
    logic    w_push, w_pop, w_res_ok;

    dtoi_front u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_char   (s_axis_tdata),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_tok    (w_front_tok)
    );

    dtoi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_front_tok),
        .i_pop   (w_pop),
        .o_tok   (w_q_tok),
        .o_stat  (w_q_stat)
    );

    dtoi_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!w_q_stat.empty),
        .i_tok       (w_q_tok),
        .o_pop       (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_ok    (w_res_ok),
        .o_res_value (m_axis_tdata)
    );

    assign m_axis_tuser = w_res_ok;

    // a failed parse never reports a value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("failed parse with nonzero value");

    // the parser only takes tokens that are present
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("token pop from empty queue");

    // a new result only appears after a terminator was retired
    a_res_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(w_pop && w_q_tok.kind == TK_END))
        else $error("result without terminator");

endmodule

@@ rtl/core/dtoi_front.sv @@
// dtoi_front: accepts characters and sorts them into tokens for the queue
// depends on dtoi_pkg
module dtoi_front (
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [dtoi_pkg::CHAR_W-1:0] i_char,
    input  dtoi_pkg::t_q_stat          i_q_stat,
    output logic                       o_push,
    output dtoi_pkg::t_tok             o_tok
);
    import dtoi_pkg::*;

    logic [CHAR_W-1:0] w_digit_full;

    assign o_ready      = !i_q_stat.full;
    assign o_push       = i_valid && !i_q_stat.full;
    assign w_digit_full = i_char - CHAR_W'(8'h30);

    always_comb begin
        o_tok.digit = w_digit_full[DIGIT_W-1:0];
        priority if (i_char == CHAR_W'(0)) begin
            o_tok.kind = TK_END;
        end else if (i_char >= CHAR_W'(8'h30) && i_char <= CHAR_W'(8'h39)) begin
            o_tok.kind = TK_DIGIT;
        end else if (i_char == CHAR_W'(8'h20) ||
                     (i_char >= CHAR_W'(8'h09) && i_char <= CHAR_W'(8'h0d))) begin
            o_tok.kind = TK_SPACE;
        end else if (i_char == CHAR_W'(8'h2b)) begin
            o_tok.kind = TK_PLUS;
        end else if (i_char == CHAR_W'(8'h2d)) begin
            o_tok.kind = TK_MINUS;
        end else begin
            o_tok.kind = TK_OTHER;
        end
    end

endmodule

@@ rtl/core/dtoi_queue.sv @@
// dtoi_queue: short token queue between the front classifier and the back parser
// depends on dtoi_pkg
module dtoi_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dtoi_pkg::t_tok     i_tok,
    input  logic               i_pop,
    output dtoi_pkg::t_tok     o_tok,
    output dtoi_pkg::t_q_stat  o_stat
);
    import dtoi_pkg::*;

    t_tok                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count, n_count;
    logic                   w_push, w_pop;

    assign o_stat.full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_tok        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (QUEUE_PTR_W+1)'(w_push) - (QUEUE_PTR_W+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

@@ rtl/core/dtoi_back.sv @@
// dtoi_back: parse state, digit accumulate with saturation and the result register
// depends on dtoi_pkg
module dtoi_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tok_valid,
    input  dtoi_pkg::t_tok             i_tok,
    output logic                       o_pop,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic                       o_res_ok,
    output logic [dtoi_pkg::OUT_W-1:0] o_res_value
);
    import dtoi_pkg::*;

    localparam int PROD_W = VALUE_BITS + 4;
    localparam int EXT_W  = (VALUE_BITS > OUT_W) ? VALUE_BITS : OUT_W;
    localparam logic [VALUE_BITS-1:0] HALF = {1'b1, {(VALUE_BITS-1){1'b0}}};

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SPACE  = 3'd1;
    localparam logic [2:0] PH_SIGN   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_BAD    = 3'd4;

    logic [2:0]            r_phase, n_phase;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_ovf, n_ovf;
    logic                  r_out_valid, n_out_valid;
    logic                  r_ok;
    logic [OUT_W-1:0]      r_val;

    logic [VALUE_BITS-1:0] w_lim;
    logic [PROD_W-1:0]     w_prod;
    logic                  w_over;
    logic [EXT_W-1:0]      w_mag_ext, w_mag_neg;
    logic                  w_end_ok;
    logic [OUT_W-1:0]      w_end_val;
    logic                  w_is_end;

    assign w_is_end = (i_tok.kind == TK_END);
    // an end token needs a free result slot, anything else just updates state
    assign o_pop    = i_tok_valid && (!w_is_end || !r_out_valid || i_res_ready);

    // m*10 + d > lim is the same test as m > (lim - d) / 10
    assign w_lim  = r_neg ? HALF : HALF - 1'b1;
    assign w_prod = (PROD_W'(r_mag) << 3) + (PROD_W'(r_mag) << 1) + PROD_W'(i_tok.digit);
    assign w_over = r_ovf || (w_prod > PROD_W'(w_lim));

    assign w_mag_ext = EXT_W'(r_mag);
    assign w_mag_neg = -w_mag_ext;
    assign w_end_ok  = (r_phase == PH_START) || (r_phase == PH_DIGITS && !r_ovf);
    assign w_end_val = !(r_phase == PH_DIGITS && !r_ovf) ? '0 :
                       r_neg ? w_mag_neg[OUT_W-1:0] : w_mag_ext[OUT_W-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_res_ready;
        if (o_pop) begin
            unique case (i_tok.kind)
                TK_END: begin
                    n_phase     = PH_START;
                    n_neg       = 1'b0;
                    n_mag       = '0;
                    n_ovf       = 1'b0;
                    n_out_valid = 1'b1;
                end
                TK_DIGIT: begin
                    if (r_phase == PH_BAD) begin
                        n_phase = PH_BAD;
                    end else begin
                        n_phase = PH_DIGITS;
                        n_ovf   = w_over;
                        n_mag   = w_over ? w_lim : w_prod[VALUE_BITS-1:0];
                    end
                end
                TK_SPACE: begin
                    n_phase = (r_phase == PH_START || r_phase == PH_SPACE) ? PH_SPACE : PH_BAD;
                end
                TK_PLUS, TK_MINUS: begin
                    if (r_phase == PH_START || r_phase == PH_SPACE) begin
                        n_phase = PH_SIGN;
                        n_neg   = (i_tok.kind == TK_MINUS);
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                default: begin
                    n_phase = PH_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_mag       <= n_mag;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_is_end) begin
            r_ok  <= w_end_ok;
            r_val <= w_end_val;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_ok    = r_ok;
    assign o_res_value = r_val;

endmodule

@@ bench/decimal_text_to_int32_tb.sv @@
// decimal_text_to_int32_tb: self-checking bench for the decimal text to int32 parser
// streams strings of characters, predicts each result and checks it on the master stream
// depends on decimal_text_to_int32 only
module decimal_text_to_int32_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS = 32;
    localparam int TEXT_ITEMS = 1650;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ST_FRESH,
        ST_BLANKS,
        ST_SIGNED,
        ST_DIGITS,
        ST_INVALID
    } t_scan_state;

    typedef struct {
        logic        ok;
        logic [31:0] value;
    } t_int_result;

    typedef struct {
        bit         hold;   // wait until every result is back
        logic [7:0] ch;
    } t_text_slot;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] text_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [31:0] parsed_value
    logic [0:0]  m_axis_tuser;            // [0] parse_ok

    t_text_slot  pending_chars[$];
    t_int_result results_due[$];
    int          mismatches = 0;
    int          text_items = 0;

    // predictor state
    t_scan_state scan_state = ST_FRESH;
    logic        minus_seen = 1'b0;
    logic [63:0] running_mag = '0;
    logic        saturated = 1'b0;

    decimal_text_to_int32 #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("error at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // advance the parse by one character, queueing a result on the terminator
    function automatic void absorb_char(input logic [7:0] c);
        logic [63:0] lim;
        logic [63:0] d;
        t_int_result r;
        if (c == CH_NUL) begin
            r.ok    = 1'b0;
            r.value = '0;
            if (scan_state == ST_FRESH) begin
                r.ok = 1'b1;
            end else if (scan_state == ST_DIGITS && !saturated) begin
                r.ok    = 1'b1;
                r.value = minus_seen ? 32'(64'd0 - running_mag) : running_mag[31:0];
            end
            results_due.push_back(r);
            scan_state  = ST_FRESH;
            minus_seen  = 1'b0;
            running_mag = '0;
            saturated   = 1'b0;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (scan_state != ST_INVALID) begin
                scan_state = ST_DIGITS;
                d   = 64'(c - CH_ZERO);
                lim = (64'd1 << (VALUE_BITS - 1)) - (minus_seen ? 64'd0 : 64'd1);
                if (saturated || running_mag > (lim - d) / 64'd10) begin
                    running_mag = lim;
                    saturated   = 1'b1;
                end else begin
                    running_mag = running_mag * 64'd10 + d;
                end
            end
        end else if ((c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                     && (scan_state == ST_FRESH || scan_state == ST_BLANKS)) begin
            scan_state = ST_BLANKS;
        end else if ((c == CH_PLUS || c == CH_MINUS)
                     && (scan_state == ST_FRESH || scan_state == ST_BLANKS)) begin
            scan_state = ST_SIGNED;
            minus_seen = (c == CH_MINUS);
        end else begin
            scan_state = ST_INVALID;
        end
    endfunction

    task automatic push_text(input string s);
        t_text_slot t;
        t.hold = 1'b0;
        for (int i = 0; i < s.len(); i++) begin
            t.ch = s[i];
            pending_chars.push_back(t);
        end
        t.ch = CH_NUL;
        pending_chars.push_back(t);
        text_items += s.len() + 1;
    endtask

    task automatic push_hold();
        t_text_slot t;
        t.hold = 1'b1;
        t.ch   = CH_NUL;
        pending_chars.push_back(t);
    endtask

    // one random string: mostly well-formed numbers, the rest broken or noise
    task automatic push_random_text();
        string       s;
        int          kind;
        int          n;
        int          p;
        logic [7:0]  c;
        longint      v;
        kind = $urandom_range(0, 19);
        s = "";
        if (kind < 13) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (int i = 0; i < n; i++) begin
                c = ($urandom_range(0, 6) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
                s = {s, string'(c)};
            end
            case ($urandom_range(0, 3))
                0: s = {s, "+"};
                1: s = {s, "-"};
                default: ;
            endcase
            case ($urandom_range(0, 3))
                0: begin
                    // close to the range limit on either side
                    v = 64'd2147483648 + $urandom_range(0, 6) - 3;
                    s = {s, $sformatf("%0d", v)};
                end
                1: s = {s, $sformatf("%0d", $urandom())};
                default: begin
                    n = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++) begin
                        c = 8'(CH_ZERO + $urandom_range(0, 9));
                        s = {s, string'(c)};
                    end
                end
            endcase
            // break some of them by one foreign character
            if (kind >= 10) begin
                c = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255))
                  : ($urandom_range(0, 1) ? CH_SPACE : CH_MINUS);
                p = $urandom_range(0, s.len());
                s = {s.substr(0, p - 1), string'(c), s.substr(p, s.len() - 1)};
            end
        end else if (kind < 16) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                c = 8'($urandom_range(1, 255));
                s = {s, string'(c)};
            end
        end else if (kind < 18) begin
            n = $urandom_range(11, 22);
            if ($urandom_range(0, 1)) s = {s, "-"};
            for (int i = 0; i < n; i++) begin
                c = 8'(CH_ZERO + $urandom_range(0, 9));
                s = {s, string'(c)};
            end
        end else begin
            case ($urandom_range(0, 3))
                0: s = "";
                1: s = " ";
                2: s = "-";
                default: s = "+";
            endcase
        end
        push_text(s);
    endtask

    // sender: bursts of random length separated by random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin : feed_chars
        logic       next_valid;
        t_text_slot t;
        next_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_char(s_axis_tdata);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_chars.size() > 0) begin
                    if (pending_chars[0].hold) begin
                        if (results_due.size() == 0) void'(pending_chars.pop_front());
                    end else begin
                        t = pending_chars.pop_front();
                        s_axis_tdata <= t.ch;
                        next_valid = 1'b1;
                        burst_left--;
                        if (burst_left <= 0) begin
                            if ($urandom_range(0, 9) == 0) begin
                                burst_left = 200;
                                gap_left   = 0;
                            end else begin
                                burst_left = $urandom_range(1, 30);
                                gap_left   = ($urandom_range(0, 4) == 0)
                                           ? $urandom_range(4, 20) : $urandom_range(0, 3);
                            end
                        end
                    end
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // receiver: runs of ready and stall of their own length
    int ready_run = 0;
    int stall_run = 0;

    always @(posedge i_clk) begin : take_results
        t_int_result r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result ok=%0b value=%0d",
                                          m_axis_tuser[0], $signed(m_axis_tdata)));
            end else begin
                r = results_due.pop_front();
                if (m_axis_tuser[0] !== r.ok)
                    report_mismatch($sformatf("parse_ok %0b, predicted %0b",
                                              m_axis_tuser[0], r.ok));
                if (m_axis_tdata !== r.value)
                    report_mismatch($sformatf("parsed_value %0d, predicted %0d",
                                              $signed(m_axis_tdata), $signed(r.value)));
            end
        end
        if (ready_run > 0) begin
            ready_run--;
            m_axis_tready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            m_axis_tready <= 1'b0;
        end else begin
            ready_run = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 10);
            stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
    end

    initial begin
        push_text("");
        push_text("0");
        push_text("2147483647");
        push_text("-2147483648");
        push_text("2147483648");
        push_text("-2147483649");
        push_text("+17");
        push_text("\011\012\013\014\015 -42");
        push_text(" \011");
        push_text("-");
        push_text("+");
        push_text("12 ");
        push_text("1-2");
        push_text("--5");
        push_text("- 5");
        push_text("9a");
        push_text("\377\200");
        push_text("-99999999999999999999");
        push_text("00000000002147483647");
        push_hold();
        while (text_items < TEXT_ITEMS) begin
            push_random_text();
            if ($urandom_range(0, 99) == 0) push_hold();
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_chars.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("decimal_text_to_int32: match");
        end else begin
            $display("decimal_text_to_int32: mismatch");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("timeout with %0d results outstanding", results_due.size());
        $display("decimal_text_to_int32: mismatch");
        $finish;
    end

endmodule

@@ decimal_text_to_int32.f @@
rtl/core/dtoi_pkg.sv
rtl/core/dtoi_front.sv
rtl/core/dtoi_queue.sv
rtl/core/dtoi_back.sv
rtl/core/decimal_text_to_int32.sv
bench/decimal_text_to_int32_tb.sv
